// ===== rtl/core/cha_pkg.sv =====
// Package: shared types and constants for the compass heading block.
package cha_pkg;
  localparam int CordicStepsDef = 16;
  localparam int TabLen = 24;
  localparam int AngW = 24;
  localparam int VecW = 42;
  localparam logic signed [16:0] MaxReset = -17'sd65536;
  localparam logic signed [16:0] MinReset = 17'sd65535;
  localparam logic [14:0] Deg360 = 15'd23040;
  localparam logic [14:0] Deg90 = 15'd5760;
  localparam logic [14:0] Deg270 = 15'd17280;
  localparam logic [AngW-1:0] Ang90 = 24'd5898240;

  typedef enum logic [1:0] {
    ST_IDLE, ST_PREP, ST_ITER, ST_DONE
  } state_e;

  function automatic logic [AngW-1:0] atan_lut(input logic [4:0] i);
    logic [AngW-1:0] r;
    case (i)
      5'd0: r = 24'd2949120;  5'd1: r = 24'd1740967; 5'd2: r = 24'd919879;
      5'd3: r = 24'd466945;   5'd4: r = 24'd234379;  5'd5: r = 24'd117304;
      5'd6: r = 24'd58666;    5'd7: r = 24'd29335;   5'd8: r = 24'd14668;
      5'd9: r = 24'd7334;     5'd10: r = 24'd3667;   5'd11: r = 24'd1833;
      5'd12: r = 24'd917;     5'd13: r = 24'd458;    5'd14: r = 24'd229;
      5'd15: r = 24'd115;     5'd16: r = 24'd57;     5'd17: r = 24'd29;
      5'd18: r = 24'd14;      5'd19: r = 24'd7;      5'd20: r = 24'd4;
      5'd21: r = 24'd2;       5'd22: r = 24'd1;      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/core/compass_heading_autocal.sv =====
// Top level: compass heading with running hard-iron min/max calibration.
// One item at a time: a new item is taken only after the last result is accepted.
// in_ready_o is low while an item is in flight or its result waits.
// Reset: min/max trackers return to their empty values, declination to 0.
module compass_heading_autocal #(
  parameter int CordicSteps = cha_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] x_set_raw_i,
  input  logic signed [15:0] y_set_raw_i,
  input  logic signed [15:0] x_reset_raw_i,
  input  logic signed [15:0] y_reset_raw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        heading_o,
  output logic [2:0]         sector_o
);
  cha_pkg::state_e st_q, st_d;
  logic signed [14:0] decl_q;
  logic signed [16:0] maxx_q, maxy_q, minx_q, miny_q;
  logic signed [16:0] maxx_d, maxy_d, minx_d, miny_d;
  logic signed [18:0] dx_q, dy_q;
  logic [1:0] quad_q;
  logic signed [16:0] xs, ys, xr, yr;
  logic [17:0] t0, t1;
  logic cstart, cdone;
  logic [14:0] ang;
  logic [14:0] head_q;
  logic [2:0] sec_q;
  logic in_acc;

  assign pready = 1'b1;
  assign prdata = {{17{decl_q[14]}}, decl_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) decl_q <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) decl_q <= pwdata[14:0];
  end

  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == cha_pkg::ST_IDLE);
  assign xs = 17'(x_set_raw_i); assign ys = 17'(y_set_raw_i);
  assign xr = 17'(x_reset_raw_i); assign yr = 17'(y_reset_raw_i);

  always_comb begin
    maxx_d = maxx_q; minx_d = minx_q; maxy_d = maxy_q; miny_d = miny_q;
    if (xs > maxx_d) maxx_d = xs;
    if (xs < minx_d) minx_d = xs;
    if (ys > maxy_d) maxy_d = ys;
    if (ys < miny_d) miny_d = ys;
    if (xr > maxx_d) maxx_d = xr;
    if (xr < minx_d) minx_d = xr;
    if (yr > maxy_d) maxy_d = yr;
    if (yr < miny_d) miny_d = yr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxx_q <= cha_pkg::MaxReset; maxy_q <= cha_pkg::MaxReset;
      minx_q <= cha_pkg::MinReset; miny_q <= cha_pkg::MinReset;
    end else if (in_acc) begin
      maxx_q <= maxx_d; maxy_q <= maxy_d; minx_q <= minx_d; miny_q <= miny_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= 19'(xs - xr) - (19'(maxx_d) + 19'(minx_d));
      dy_q <= 19'(ys - yr) - (19'(maxy_d) + 19'(miny_d));
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == cha_pkg::ST_PREP) quad_q <= {dx_q < 0, dy_q > 0};
  end

  logic [18:0] ax, ay;
  assign ax = dx_q < 0 ? 19'(-dx_q) : 19'(dx_q);
  assign ay = dy_q < 0 ? 19'(-dy_q) : 19'(dy_q);
  assign t1 = ax[17:0];
  assign t0 = ay[17:0];
  assign cstart = (st_q == cha_pkg::ST_PREP);

  cha_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .t0_i(t0), .t1_i(t1),
    .done_o(cdone), .ang_o(ang)
  );

  logic signed [17:0] h0, h1;
  logic [2:0] sec;
  always_comb begin
    case (quad_q)
      2'b11: h0 = 18'(cha_pkg::Deg90) - 18'(ang);
      2'b10: h0 = 18'(cha_pkg::Deg90) + 18'(ang);
      2'b00: h0 = 18'(cha_pkg::Deg270) - 18'(ang);
      default: h0 = 18'(cha_pkg::Deg270) + 18'(ang);
    endcase
    // quad 00 means dx>=0, dy<=0; dy==0 gives ang 0 either way
    if (quad_q == 2'b00 && dy_q == 0) h0 = 18'(cha_pkg::Deg270) + 18'(ang);
    h1 = h0 + 18'(decl_q);
    if (decl_q > 0) begin
      if (h1 > 18'sd23040) h1 = h1 - 18'sd23040;
    end else if (h1 < 0) h1 = h1 + 18'sd23040;
    if (h1 > 18'sd21600 || h1 < 18'sd1440) sec = 3'd0;
    else if (h1 > 18'sd18720) sec = 3'd7;
    else if (h1 > 18'sd15840) sec = 3'd6;
    else if (h1 > 18'sd12960) sec = 3'd5;
    else if (h1 > 18'sd10080) sec = 3'd4;
    else if (h1 > 18'sd7200) sec = 3'd3;
    else if (h1 > 18'sd4320) sec = 3'd2;
    else sec = 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cdone) begin
      head_q <= h1[14:0]; sec_q <= sec;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      cha_pkg::ST_IDLE: if (in_acc) st_d = cha_pkg::ST_PREP;
      cha_pkg::ST_PREP: st_d = cha_pkg::ST_ITER;
      cha_pkg::ST_ITER: if (cdone) st_d = cha_pkg::ST_DONE;
      cha_pkg::ST_DONE: if (out_ready_i) st_d = cha_pkg::ST_IDLE;
      default: st_d = cha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= cha_pkg::ST_IDLE;
    else st_q <= st_d;
  end

  assign out_valid_o = (st_q == cha_pkg::ST_DONE);
  assign heading_o = head_q;
  assign sector_o = sec_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(heading_o))
    else $error("result changed while stalled");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_o <= cha_pkg::Deg360)
    else $error("heading out of range");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("accepting while result pending");
endmodule

// ===== rtl/core/cha_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle.
module cha_cordic #(
  parameter int CordicSteps = cha_pkg::CordicStepsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [17:0]                t0_i,
  input  logic [17:0]                t1_i,
  output logic                       done_o,
  output logic [14:0]                ang_o
);
  localparam int CntW = $clog2(CordicSteps + 1);
  localparam int VW = cha_pkg::VecW;

  logic signed [VW-1:0] x_q, x_d, y_q, y_d;
  logic signed [VW:0] z_q, z_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic signed [VW-1:0] dx, dy;
  logic signed [VW:0] tab, zc;

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign tab = $signed({{(VW+1-cha_pkg::AngW){1'b0}}, cha_pkg::atan_lut(5'(cnt_q))});

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      x_d = $signed({{(VW-38){1'b0}}, t1_i, 20'd0});
      y_d = $signed({{(VW-38){1'b0}}, t0_i, 20'd0});
      z_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + tab;
      end else if (y_q < 0) begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - tab;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(CordicSteps - 1)) busy_d = 1'b0;
    end
  end

  assign done_d = busy_q && !busy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  always_comb begin
    if (z_q < 0) zc = '0;
    else if (z_q > $signed({{(VW+1-cha_pkg::AngW){1'b0}}, cha_pkg::Ang90}))
      zc = $signed({{(VW+1-cha_pkg::AngW){1'b0}}, cha_pkg::Ang90});
    else zc = z_q;
  end
  logic [VW:0] zr;
  assign zr = zc + (VW+1)'(512);
  assign ang_o = zr[24:10];
  assign done_o = done_q;
endmodule
